// ----- sv/sll_pkg.sv -----
// Shared types, constants and character-class functions for the small language lexer.
package sll_pkg;

  // Source size bound and the offset at which byte positions stop counting
  localparam int unsigned MaxSourceBytes = 65536;
  localparam int unsigned PosTopInt =
      (MaxSourceBytes - 1 > 65535) ? 65535 : (MaxSourceBytes - 1);
  localparam logic [15:0] PosTop = 16'(PosTopInt);

  // Keyword "procedure" length
  localparam logic [3:0] KwLen = 4'd9;

  // Result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = $clog2(QDepth);

  // Token kinds as seen on the result stream
  typedef enum logic [3:0] {
    TkIdent   = 4'd0,
    TkProc    = 4'd1,
    TkInt     = 4'd2,
    TkSemi    = 4'd3,
    TkLbrace  = 4'd4,
    TkRbrace  = 4'd5,
    TkLparen  = 4'd6,
    TkRparen  = 4'd7,
    TkPercent = 4'd8,
    TkStar    = 4'd9,
    TkSlash   = 4'd10,
    TkPlus    = 4'd11,
    TkMinus   = 4'd12,
    TkEquals  = 4'd13,
    TkNoMore  = 4'd14
  } tok_kind_e;

  // One result item
  typedef struct packed {
    tok_kind_e   kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } tok_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  // Expected keyword byte at a given match index
  function automatic logic [7:0] kw_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "p";
      4'd1:    c = "r";
      4'd2:    c = "o";
      4'd3:    c = "c";
      4'd4:    c = "e";
      4'd5:    c = "d";
      4'd6:    c = "u";
      4'd7:    c = "r";
      4'd8:    c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Single-character token kind; TkNoMore when the byte is not one of them
  function automatic tok_kind_e single_kind(input logic [7:0] c);
    tok_kind_e k;
    unique case (c)
      ";":     k = TkSemi;
      "{":     k = TkLbrace;
      "}":     k = TkRbrace;
      "(":     k = TkLparen;
      ")":     k = TkRparen;
      "%":     k = TkPercent;
      "*":     k = TkStar;
      "+":     k = TkPlus;
      "-":     k = TkMinus;
      "=":     k = TkEquals;
      default: k = TkNoMore;
    endcase
    return k;
  endfunction

endpackage

// ----- sv/sll_core.sv -----
// Lexer state registers and the single-pass step that turns one byte into up to two tokens.
module sll_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_accept_i,
  input  logic          in_end_i,
  input  logic [7:0]    in_char_i,
  output logic [1:0]    res_cnt_o,
  output sll_pkg::tok_t res0_o,
  output sll_pkg::tok_t res1_o
);
  import sll_pkg::*;

  localparam logic [2:0] ModeIdle  = 3'd0;
  localparam logic [2:0] ModeIdent = 3'd1;
  localparam logic [2:0] ModeInt   = 3'd2;
  localparam logic [2:0] ModeSlash = 3'd3;
  localparam logic [2:0] ModeLine  = 3'd4;
  localparam logic [2:0] ModeBlock = 3'd5;
  localparam logic [2:0] ModeStar  = 3'd6;

  logic [2:0]  mode_q, mode_d;
  logic [15:0] begin_q, begin_d;
  logic [15:0] pos_q, pos_d;
  logic [3:0]  kw_idx_q, kw_idx_d;
  logic        kw_ok_q, kw_ok_d;
  logic        halted_q, halted_d;

  logic [15:0] span;
  logic        pending;
  tok_t        flush_tok;
  logic        do_flush;
  logic        go_idle;
  logic        sec_valid;
  tok_t        sec_tok;
  tok_kind_e   sk;
  logic [1:0]  cnt;

  // Length of the pending run
  assign span = (pos_q >= begin_q) ? (pos_q - begin_q) : '0;
  assign sk   = single_kind(in_char_i);

  // Pending token as it would be flushed by this beat
  always_comb begin
    pending         = 1'b0;
    flush_tok       = '0;
    flush_tok.start = begin_q;
    flush_tok.len   = span;
    unique case (mode_q)
      ModeIdent: begin
        pending = 1'b1;
        flush_tok.kind = (kw_ok_q && (kw_idx_q == KwLen) && (in_end_i || (in_char_i != "_")))
                         ? TkProc : TkIdent;
      end
      ModeInt: begin
        pending        = 1'b1;
        flush_tok.kind = TkInt;
      end
      ModeSlash: begin
        pending        = 1'b1;
        flush_tok.kind = TkSlash;
        flush_tok.len  = 16'd1;
      end
      default: begin
        pending = 1'b0;
      end
    endcase
  end

  // Next state and the beat's results
  always_comb begin
    mode_d    = mode_q;
    begin_d   = begin_q;
    pos_d     = pos_q;
    kw_idx_d  = kw_idx_q;
    kw_ok_d   = kw_ok_q;
    halted_d  = halted_q;
    do_flush  = 1'b0;
    go_idle   = 1'b0;
    sec_valid = 1'b0;
    sec_tok   = '0;
    sec_tok.start = pos_q;

    if (in_end_i) begin
      // End of source: flush and mark unless halted, and always return to reset state
      if (!halted_q) begin
        do_flush     = pending;
        sec_valid    = 1'b1;
        sec_tok.kind = TkNoMore;
      end
      mode_d   = ModeIdle;
      begin_d  = '0;
      pos_d    = '0;
      kw_idx_d = '0;
      kw_ok_d  = 1'b1;
      halted_d = 1'b0;
    end else if (!halted_q) begin
      // Advance the current run or comment
      unique case (mode_q)
        ModeIdent: begin
          if (is_letter(in_char_i) || is_digit(in_char_i)) begin
            if (kw_ok_q && (kw_idx_q < KwLen) && (in_char_i == kw_char(kw_idx_q))) begin
              kw_idx_d = kw_idx_q + 4'd1;
            end else begin
              kw_ok_d = 1'b0;
            end
          end else begin
            do_flush = 1'b1;
            go_idle  = 1'b1;
          end
        end
        ModeInt: begin
          if (!is_digit(in_char_i)) begin
            do_flush = 1'b1;
            go_idle  = 1'b1;
          end
        end
        ModeSlash: begin
          if (in_char_i == "/") begin
            mode_d = ModeLine;
          end else if (in_char_i == "*") begin
            mode_d = ModeBlock;
          end else begin
            do_flush = 1'b1;
            go_idle  = 1'b1;
          end
        end
        ModeLine: begin
          if ((in_char_i == 8'h0a) || (in_char_i == 8'h0d)) begin
            go_idle = 1'b1;
          end
        end
        ModeBlock: begin
          if (in_char_i == "*") begin
            mode_d = ModeStar;
          end
        end
        ModeStar: begin
          if (in_char_i == "/") begin
            mode_d = ModeIdle;
          end else if (in_char_i != "*") begin
            mode_d = ModeBlock;
          end
        end
        default: begin
          go_idle = 1'b1;
        end
      endcase

      // Start a new token from idle
      if (go_idle) begin
        mode_d = ModeIdle;
        priority if (is_space(in_char_i)) begin
          mode_d = ModeIdle;
        end else if (is_letter(in_char_i)) begin
          mode_d   = ModeIdent;
          begin_d  = pos_q;
          kw_ok_d  = (in_char_i == "p");
          kw_idx_d = (in_char_i == "p") ? 4'd1 : 4'd0;
        end else if (in_char_i == "0") begin
          sec_valid    = 1'b1;
          sec_tok.kind = TkInt;
          sec_tok.len  = 16'd1;
        end else if (is_digit(in_char_i)) begin
          mode_d  = ModeInt;
          begin_d = pos_q;
        end else if (in_char_i == "/") begin
          mode_d  = ModeSlash;
          begin_d = pos_q;
        end else if (sk != TkNoMore) begin
          sec_valid    = 1'b1;
          sec_tok.kind = sk;
          sec_tok.len  = 16'd1;
        end else begin
          sec_valid    = 1'b1;
          sec_tok.kind = TkNoMore;
          halted_d     = 1'b1;
        end
      end

      // Saturating byte offset
      if (pos_q < PosTop) begin
        pos_d = pos_q + 16'd1;
      end
    end
  end

  // Order the results and tag the final one
  always_comb begin
    res0_o = '0;
    res1_o = '0;
    cnt    = 2'd0;
    if (do_flush) begin
      res0_o = flush_tok;
      if (sec_valid) begin
        res1_o      = sec_tok;
        res1_o.last = 1'b1;
        cnt         = 2'd2;
      end else begin
        res0_o.last = 1'b1;
        cnt         = 2'd1;
      end
    end else if (sec_valid) begin
      res0_o      = sec_tok;
      res0_o.last = 1'b1;
      cnt         = 2'd1;
    end
    res_cnt_o = in_accept_i ? cnt : 2'd0;
  end

  // Hold state between accepted beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      begin_q  <= '0;
      pos_q    <= '0;
      kw_idx_q <= '0;
      kw_ok_q  <= 1'b1;
      halted_q <= 1'b0;
    end else if (in_accept_i) begin
      mode_q   <= mode_d;
      begin_q  <= begin_d;
      pos_q    <= pos_d;
      kw_idx_q <= kw_idx_d;
      kw_ok_q  <= kw_ok_d;
      halted_q <= halted_d;
    end
  end

endmodule

// ----- sv/sll_outq.sv -----
// Small result queue taking up to two tokens per cycle and releasing one per cycle when popped.
module sll_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_cnt_i,
  input  sll_pkg::tok_t push0_i,
  input  sll_pkg::tok_t push1_i,
  input  logic          pop_i,
  output logic          room_o,
  output logic          valid_o,
  output sll_pkg::tok_t head_o
);
  import sll_pkg::*;

  tok_t         mem_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAw:0]   cnt_q, cnt_d;
  logic [QAw-1:0] wr_ptr_nx;

  assign wr_ptr_nx = wr_ptr_q + QAw'(1);

  // Room for a full pair of results
  assign room_o  = (cnt_q <= (QAw+1)'(QDepth - 2));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q + QAw'(push_cnt_i);
    rd_ptr_d = pop_i ? (rd_ptr_q + QAw'(1)) : rd_ptr_q;
    cnt_d    = cnt_q + (QAw+1)'(push_cnt_i) - (QAw+1)'(pop_i);
  end

  // Store pushed beats
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- sv/small_language_lexer.sv -----
// Top level of the small language lexer: byte stream in, token stream out.
//
//   Channel   Dir  Beat carries
//   s_axis    in   one source byte (tdata) and an end-of-source flag (tuser)
//   m_axis    out  one token: kind, start offset, length; tlast on the final
//                  token caused by one source beat
//
// One source beat is taken per cycle while the queue has room; its tokens
// are computed in the same cycle from the lexer state and written into a
// four-entry result queue. A beat may yield two tokens, so input is held
// off while fewer than two queue entries are free; the queue drains at one
// token per cycle while m_axis_tready is high. Reset clears the lexer state
// and empties the queue; no clearing pass. Tokens leave m_axis in order.
module small_language_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tuser,   // [0] kind: 1 = end of source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [3:0] token_kind, [19:4] token_start,
                                      // [35:20] token_length, [39:36] zero
  output logic        m_axis_tlast    // last_of_run
);
  import sll_pkg::*;

  logic       in_accept;
  logic       out_pop;
  logic [1:0] res_cnt;
  tok_t       res0;
  tok_t       res1;
  tok_t       head;
  logic       room;
  logic       head_valid;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_pop   = m_axis_tvalid && m_axis_tready;

  // Lexer step
  sll_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_end_i    (s_axis_tuser),
    .in_char_i   (s_axis_tdata),
    .res_cnt_o   (res_cnt),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  // Result queue
  sll_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (res_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .pop_i      (out_pop),
    .room_o     (room),
    .valid_o    (head_valid),
    .head_o     (head)
  );

  // Drive the stream ports
  assign s_axis_tready = room;
  assign m_axis_tvalid = head_valid;
  assign m_axis_tdata  = {4'b0000, head.len, head.start, head.kind};
  assign m_axis_tlast  = head.last;

  // Results only arise from an accepted beat
  a_res_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |-> (res_cnt == 2'd0))
    else $error("tokens produced without an accepted source beat");

  // A stalled input side means queued tokens are on offer
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with nothing to deliver");

  // End of source closes with the no-more marker
  a_end_marker_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s_axis_tuser && (res_cnt == 2'd2)) |-> (res1.kind == TkNoMore))
    else $error("end of source did not close with the no-more marker");

  a_end_marker_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s_axis_tuser && (res_cnt == 2'd1)) |-> (res0.kind == TkNoMore))
    else $error("end of source did not emit the no-more marker");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the small language lexer: token scoreboard and stream drivers.

// Scoreboard: tracks the lexer state and holds the tokens still to arrive
class lexer_scoreboard;
  typedef enum logic [2:0] {
    LxIdle, LxIdent, LxInt, LxSlash, LxLine, LxBlock, LxStar
  } lex_mode_e;

  lex_mode_e          mode;
  logic [15:0]        tok_begin;
  logic [15:0]        src_pos;
  logic [3:0]         kw_idx;
  bit                 kw_live;
  bit                 stopped;
  string              kw_word;
  sll_pkg::tok_t      expected_q[$];
  int unsigned        errors;

  function new();
    kw_word = "procedure";
    errors  = 0;
    restart();
  endfunction

  function void restart();
    mode      = LxIdle;
    tok_begin = '0;
    src_pos   = '0;
    kw_idx    = '0;
    kw_live   = 1'b1;
    stopped   = 1'b0;
  endfunction

  function bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function bit blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // Map a punctuation byte to its token kind; hit is low for any other byte
  function void punct(logic [7:0] c, output bit hit, output sll_pkg::tok_kind_e k);
    hit = 1'b1;
    k   = sll_pkg::TkNoMore;
    case (c)
      ";":     k = sll_pkg::TkSemi;
      "{":     k = sll_pkg::TkLbrace;
      "}":     k = sll_pkg::TkRbrace;
      "(":     k = sll_pkg::TkLparen;
      ")":     k = sll_pkg::TkRparen;
      "%":     k = sll_pkg::TkPercent;
      "*":     k = sll_pkg::TkStar;
      "+":     k = sll_pkg::TkPlus;
      "-":     k = sll_pkg::TkMinus;
      "=":     k = sll_pkg::TkEquals;
      default: hit = 1'b0;
    endcase
  endfunction

  function void push_token(sll_pkg::tok_kind_e k, logic [15:0] s, logic [15:0] l);
    sll_pkg::tok_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    t.last  = 1'b0;
    expected_q.push_back(t);
  endfunction

  // Emit whatever token is pending; an underscore ender spoils the keyword
  function void flush_pending(bit by_underscore);
    logic [15:0] span;
    bit kw;
    span = (src_pos >= tok_begin) ? src_pos - tok_begin : 16'd0;
    case (mode)
      LxIdent: begin
        kw = kw_live && kw_idx == sll_pkg::KwLen && !by_underscore;
        push_token(kw ? sll_pkg::TkProc : sll_pkg::TkIdent, tok_begin, span);
      end
      LxInt:   push_token(sll_pkg::TkInt, tok_begin, span);
      LxSlash: push_token(sll_pkg::TkSlash, tok_begin, 16'd1);
      default: ;
    endcase
    mode = LxIdle;
  endfunction

  // Note one accepted source beat and queue the tokens it causes
  function void note_beat(bit eos, logic [7:0] c);
    int n0;
    bit to_idle;
    bit hit;
    sll_pkg::tok_kind_e pk;
    n0      = expected_q.size();
    to_idle = 1'b0;
    if (eos) begin
      if (!stopped) begin
        flush_pending(1'b0);
        push_token(sll_pkg::TkNoMore, src_pos, 16'd0);
      end
      restart();
    end else if (!stopped) begin
      case (mode)
        LxIdent: begin
          if (letter(c) || digit(c)) begin
            if (kw_live && kw_idx < sll_pkg::KwLen && c == 8'(kw_word[kw_idx]))
              kw_idx++;
            else
              kw_live = 1'b0;
          end else begin
            flush_pending(c == "_");
            to_idle = 1'b1;
          end
        end
        LxInt: begin
          if (!digit(c)) begin
            flush_pending(c == "_");
            to_idle = 1'b1;
          end
        end
        LxSlash: begin
          if (c == "/") mode = LxLine;
          else if (c == "*") mode = LxBlock;
          else begin
            flush_pending(c == "_");
            to_idle = 1'b1;
          end
        end
        LxLine: begin
          if (c == 8'h0a || c == 8'h0d) begin
            mode    = LxIdle;
            to_idle = 1'b1;
          end
        end
        LxBlock: if (c == "*") mode = LxStar;
        LxStar: begin
          if (c == "/") mode = LxIdle;
          else if (c != "*") mode = LxBlock;
        end
        default: begin
          mode    = LxIdle;
          to_idle = 1'b1;
        end
      endcase

      // Start a new token from the current byte
      if (to_idle) begin
        punct(c, hit, pk);
        if (blank(c)) begin
        end else if (letter(c)) begin
          mode      = LxIdent;
          tok_begin = src_pos;
          kw_live   = (c == "p");
          kw_idx    = (c == "p") ? 4'd1 : 4'd0;
        end else if (c == "0") begin
          push_token(sll_pkg::TkInt, src_pos, 16'd1);
        end else if (digit(c)) begin
          mode      = LxInt;
          tok_begin = src_pos;
        end else if (c == "/") begin
          mode      = LxSlash;
          tok_begin = src_pos;
        end else if (hit) begin
          push_token(pk, src_pos, 16'd1);
        end else begin
          push_token(sll_pkg::TkNoMore, src_pos, 16'd0);
          stopped = 1'b1;
          mode    = LxIdle;
        end
      end

      if (src_pos < sll_pkg::PosTop) src_pos++;
    end
    if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  // Compare one accepted token beat with the oldest expectation
  function void check_token(logic [39:0] d, logic tl);
    sll_pkg::tok_t want;
    if (expected_q.size() == 0) begin
      $error("token kind %0d start %0d arrived with nothing expected", d[3:0], d[19:4]);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (d[3:0] !== want.kind) begin
      $error("token_kind: expected %0d, actual %0d", want.kind, d[3:0]);
      errors++;
    end
    if (d[19:4] !== want.start) begin
      $error("token_start: expected %0d, actual %0d", want.start, d[19:4]);
      errors++;
    end
    if (d[35:20] !== want.len) begin
      $error("token_length: expected %0d, actual %0d", want.len, d[35:20]);
      errors++;
    end
    if (tl !== want.last) begin
      $error("last_of_run: expected %0d, actual %0d", want.last, tl);
      errors++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned RandomBeats = 1050;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] character
  logic        s_axis_tuser  = 1'b0;   // [0] kind: 1 = end of source
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;           // [3:0] token_kind, [19:4] token_start,
                                       // [35:20] token_length, [39:36] zero
  logic        m_axis_tlast;           // last_of_run

  bit          src_idle_en = 1'b1;
  bit          snk_idle_en = 1'b1;
  int unsigned stall_left  = 0;
  int unsigned cycle_count = 0;
  lexer_scoreboard sb = new();

  small_language_lexer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Watch both channels and stall the token side in random bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_beat(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_token(m_axis_tdata, m_axis_tlast);
    end
    if (snk_idle_en && stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Drive one source beat, with an optional gap before it
  task automatic send_beat(input bit eos, input logic [7:0] c);
    int unsigned gap;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= eos;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_source(input logic [7:0] src[$], input logic [7:0] end_char);
    foreach (src[i]) send_beat(1'b0, src[i]);
    send_beat(1'b1, end_char);
  endtask

  task automatic send_text(input string s, input logic [7:0] end_char);
    for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
    send_beat(1'b1, end_char);
  endtask

  // Hold the source side until every expected token has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] blank_byte();
    return ($urandom_range(0, 5) == 5) ? 8'h20 : 8'(9 + $urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] alnum_byte();
    int unsigned r;
    r = $urandom_range(0, 61);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return 8'("0" + r - 52);
  endfunction

  // Build one source: mostly well-formed tokens, comments and spacing
  function automatic void build_source(ref logic [7:0] src[$]);
    string       kw;
    string       puncts;
    int unsigned n_tok;
    int unsigned sel;
    int unsigned k;
    kw     = "procedure";
    puncts = ";{}()%*+-=";
    src.delete();
    n_tok  = $urandom_range(1, 20);
    for (int t = 0; t < n_tok; t++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        case ($urandom_range(0, 4))
          0: for (int i = 0; i < 9; i++) src.push_back(kw[i]);
          1: begin
            for (int i = 0; i < 9; i++) src.push_back(kw[i]);
            repeat ($urandom_range(1, 3)) src.push_back(alnum_byte());
          end
          2: begin
            k = $urandom_range(1, 8);
            for (int i = 0; i < k; i++) src.push_back(kw[i]);
          end
          default: begin
            src.push_back(($urandom_range(0, 1) != 0) ? 8'("a" + $urandom_range(0, 25))
                                                    : 8'("A" + $urandom_range(0, 25)));
            repeat ($urandom_range(0, 6)) src.push_back(alnum_byte());
          end
        endcase
      end else if (sel < 45) begin
        if ($urandom_range(0, 3) == 0) src.push_back("0");
        else begin
          src.push_back(8'("1" + $urandom_range(0, 8)));
          repeat ($urandom_range(0, 4)) src.push_back(8'("0" + $urandom_range(0, 9)));
        end
      end else if (sel < 65) begin
        src.push_back(puncts[$urandom_range(0, 9)]);
      end else if (sel < 70) begin
        src.push_back("/");
      end else if (sel < 78) begin
        // Line comment with arbitrary content apart from line ends
        src.push_back("/");
        src.push_back("/");
        repeat ($urandom_range(0, 8)) begin
          k = $urandom_range(0, 255);
          src.push_back((k == 8'h0a || k == 8'h0d) ? 8'h80 : 8'(k));
        end
        src.push_back(($urandom_range(0, 1) != 0) ? 8'h0a : 8'h0d);
      end else if (sel < 86) begin
        // Block comment, stars scattered through the body
        src.push_back("/");
        src.push_back("*");
        repeat ($urandom_range(0, 8))
          src.push_back(($urandom_range(0, 3) == 0) ? 8'h2a : 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 2)) src.push_back("*");
        src.push_back("/");
      end else if (sel < 98) begin
        src.push_back(blank_byte());
      end else begin
        // Noise byte, then end the source after up to two more random bytes
        src.push_back(($urandom_range(0, 1) != 0) ? 8'h5f : 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) src.push_back(8'($urandom_range(0, 255)));
        break;
      end
      if ($urandom_range(0, 9) < 6) src.push_back(blank_byte());
    end
    // Occasionally leave a block comment open up to the end marker
    if ($urandom_range(0, 19) == 0) begin
      src.push_back("/");
      src.push_back("*");
      repeat ($urandom_range(0, 5)) src.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    logic [7:0]  src[$];
    string       dir_text;
    int unsigned sent_random;
    bit          drained_mid;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: keyword spoilt by underscore, ignored bytes while halted, silent end
    dir_text = "procedure_";
    src.delete();
    for (int i = 0; i < dir_text.len(); i++) src.push_back(dir_text[i]);
    src.push_back(8'hff);
    src.push_back(8'h00);
    send_source(src, 8'hff);
    // Ident ended by slash, lone slash, open block comment
    send_text("b/ /*", 8'h00);
    // Keyword flushed by the end marker
    send_text("procedure", 8'h5a);
    drain();

    // Random sources; the tail runs with no idling
    sent_random = 0;
    drained_mid = 1'b0;
    while (sent_random < RandomBeats) begin
      src_idle_en = (sent_random < RandomBeats - 170);
      snk_idle_en = src_idle_en;
      build_source(src);
      send_source(src, 8'($urandom_range(0, 255)));
      sent_random += src.size() + 1;
      if (!drained_mid && sent_random >= RandomBeats / 2) begin
        drain();
        drained_mid = 1'b1;
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
